[rtl/sem_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, codes and types for the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  // Pixel and window geometry.
  localparam int PIX_W     = 8;
  localparam int NUM_LANES = 3;
  localparam int RGB_W     = PIX_W * NUM_LANES;
  localparam int TAPS      = 9;
  localparam int ROW_W     = 12;
  localparam int FW_W      = 11;

  // Lane arithmetic: absolute gradient, its square, the sum and the root.
  localparam int GRAD_W = PIX_W + 2;
  localparam int SQ_W   = 2 * GRAD_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int ROOT_W = PIX_W;
  localparam int PROD_W = 2 * ROOT_W;
  localparam int BIT_W  = $clog2(ROOT_W);

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Request kinds carried in tuser.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Register reset values.
  localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd480;

  // 3x3 window, row-major, one RGB word or one channel per tap.
  typedef logic [TAPS-1:0][RGB_W-1:0] rgb_win_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] chan_win_t;

  // Control from the sequencer to the line stores and window.
  typedef struct packed {
    logic             rd_en;
    logic             shift_en;
    logic             wr_en;
    logic [RGB_W-1:0] bot_pix;
  } win_cmd_t;

  // Result of one channel lane.
  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] mag;
  } lane_res_t;

endpackage

[rtl/sem_window.sv]
// ----------------------------------------------------------------------------
// Sobel line stores and window
// Two line memories and the 3x3 pixel window that slides one column a shift.
// ----------------------------------------------------------------------------
module sem_window import sem_pkg::*; #(
  parameter int MAX_LINE = 1024,
  parameter int CW       = $clog2(MAX_LINE)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  win_cmd_t      cmd_i,
  input  logic [CW-1:0] rd_addr_i,
  output rgb_win_t      taps_o
);

  logic [RGB_W-1:0] upper_mem  [MAX_LINE];
  logic [RGB_W-1:0] middle_mem [MAX_LINE];
  logic [RGB_W-1:0] upper_rd_q;
  logic [RGB_W-1:0] middle_rd_q;
  logic [CW-1:0]    addr_q;
  rgb_win_t         window_q;

  // Registered read of both line stores; the address is kept for the write back.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      upper_rd_q  <= upper_mem[rd_addr_i];
      middle_rd_q <= middle_mem[rd_addr_i];
      addr_q      <= rd_addr_i;
    end
  end

  // Each line moves up one store: the middle line becomes the upper one.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      upper_mem[addr_q]  <= middle_rd_q;
      middle_mem[addr_q] <= cmd_i.bot_pix;
    end
  end

  // Slide the window left and load the new column on the right.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (cmd_i.shift_en) begin
      for (int r = 0; r < 3; r++) begin
        window_q[r*3+0] <= window_q[r*3+1];
        window_q[r*3+1] <= window_q[r*3+2];
      end
      window_q[2] <= upper_rd_q;
      window_q[5] <= middle_rd_q;
      window_q[8] <= cmd_i.bot_pix;
    end
  end

  assign taps_o = window_q;

endmodule

[rtl/sem_lane.sv]
// ----------------------------------------------------------------------------
// Sobel channel lane
// Gradient, sum of squares and a rounded integer square root for one channel.
// ----------------------------------------------------------------------------
module sem_lane import sem_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  chan_win_t taps_i,
  output lane_res_t res_o
);

  typedef enum logic [2:0] {
    L_IDLE,
    L_SQUARE,
    L_SUM,
    L_ROOT,
    L_DONE
  } lane_state_e;

  lane_state_e        state_q;
  logic [GRAD_W-1:0]  ax_q, ay_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [SUM_W-1:0]   sum_q;
  logic [ROOT_W-1:0]  root_q;
  logic [BIT_W-1:0]   bit_q;

  logic [GRAD_W-1:0]  pos_x, neg_x, pos_y, neg_y, abs_x, abs_y;
  logic [ROOT_W-1:0]  cand;
  logic [PROD_W-1:0]  prod;
  logic               root_hit;

  // Both Sobel kernels split into their positive and negative halves.
  assign pos_x = GRAD_W'(taps_i[2]) + GRAD_W'({taps_i[5], 1'b0}) + GRAD_W'(taps_i[8]);
  assign neg_x = GRAD_W'(taps_i[0]) + GRAD_W'({taps_i[3], 1'b0}) + GRAD_W'(taps_i[6]);
  assign pos_y = GRAD_W'(taps_i[6]) + GRAD_W'({taps_i[7], 1'b0}) + GRAD_W'(taps_i[8]);
  assign neg_y = GRAD_W'(taps_i[0]) + GRAD_W'({taps_i[1], 1'b0}) + GRAD_W'(taps_i[2]);
  assign abs_x = (pos_x >= neg_x) ? pos_x - neg_x : neg_x - pos_x;
  assign abs_y = (pos_y >= neg_y) ? pos_y - neg_y : neg_y - pos_y;

  // One root bit per cycle: keep the candidate while k*(k-1) < s,
  // which is k*k-k+1 <= s, the rounding threshold of the square root.
  assign cand     = root_q | (ROOT_W'(1) << bit_q);
  assign prod     = PROD_W'(cand) * PROD_W'(cand - ROOT_W'(1));
  assign root_hit = SUM_W'(prod) < sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      ax_q    <= '0;
      ay_q    <= '0;
      sqx_q   <= '0;
      sqy_q   <= '0;
      sum_q   <= '0;
      root_q  <= '0;
      bit_q   <= '0;
    end else if (start_i) begin
      ax_q    <= abs_x;
      ay_q    <= abs_y;
      state_q <= L_SQUARE;
    end else begin
      case (state_q)
        L_SQUARE: begin
          sqx_q   <= SQ_W'(ax_q) * SQ_W'(ax_q);
          sqy_q   <= SQ_W'(ay_q) * SQ_W'(ay_q);
          state_q <= L_SUM;
        end
        L_SUM: begin
          sum_q   <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
          root_q  <= '0;
          bit_q   <= BIT_W'(ROOT_W - 1);
          state_q <= L_ROOT;
        end
        L_ROOT: begin
          if (root_hit) begin
            root_q <= cand;
          end
          if (bit_q == '0) begin
            state_q <= L_DONE;
          end else begin
            bit_q <= bit_q - BIT_W'(1);
          end
        end
        L_IDLE, L_DONE: begin
          state_q <= state_q;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign res_o.done = (state_q == L_DONE);
  assign res_o.mag  = root_q;

endmodule

[rtl/sobel_edge_magnitude_rgb.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel gradient magnitude per color channel, zero outside the
// frame, with line stores, three channel lanes and a merging output register.
// ----------------------------------------------------------------------------
//  Channel   Dir  Contents
//  s_axis    in   tdata = red, green, blue; tuser = request kind (pixel / drain)
//  m_axis    out  tdata = edge red, edge green, edge blue; tlast = frame end
//  apb       in   frame_width at 0x0, frame_height at 0x4
//
// A pixel that yields a result occupies the block for one memory read, one
// window shift, one tap capture, then square, sum and the eight-step square-root
// iteration in each lane. A pixel without a result is only read and shifted in;
// a one-row frame's last pixel adds an extra column. Drains go as result pixels.
// Reset clears all counters and the window; the line stores need no clearing.
// The result register holds a stalled result while the next request is taken.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
  parameter int MAX_LINE = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [RGB_W-1:0]      s_axis_tdata,   // pixel_red, pixel_green, pixel_blue
  input  logic                  s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [RGB_W-1:0]      m_axis_tdata,   // edge_red, edge_green, edge_blue
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int WW = $clog2(MAX_LINE + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT,
    ST_XREAD,
    ST_XSHIFT,
    ST_WAIT
  } seq_state_e;

  seq_state_e          state_q;
  logic [FW_W-1:0]     frame_width_q;
  logic [ROW_W-1:0]    frame_height_q;
  logic [CW-1:0]       in_col_q, out_col_q;
  logic [ROW_W-1:0]    in_row_q, out_row_q;
  logic                drain_pend_q;
  logic                is_pix_q;
  logic                emit_q;
  logic                extra_q;
  logic [RGB_W-1:0]    pix_q;
  logic                fend_q;
  logic                out_valid_q;
  logic [RGB_W-1:0]    out_data_q;
  logic                out_last_q;

  logic                cfg_wr;
  logic                accept;
  logic [WW-1:0]       weff;
  logic [ROW_W-1:0]    heff;
  logic [WW-1:0]       in_col_inc, out_col_inc;
  logic [ROW_W:0]      in_row_inc, out_row_inc;
  logic                in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
  logic                emit_now;
  logic [CW-1:0]       drain_addr, rd_addr;
  logic                row_first, row_last, col_first, col_last;
  logic [TAPS-1:0]     keep;
  win_cmd_t            win_cmd;
  rgb_win_t            win_taps;
  chan_win_t           lane_taps [NUM_LANES];
  lane_res_t           lane_res  [NUM_LANES];
  logic                lanes_done;
  logic                out_free;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[ROW_W-1:0];
        default:          frame_width_q  <= frame_width_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, width is limited to the line store.
  always_comb begin
    if (frame_width_q == '0) begin
      weff = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_LINE)) begin
      weff = WW'(MAX_LINE);
    end else begin
      weff = WW'(frame_width_q);
    end
    heff = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;
  end

  // Position arithmetic for the input and output raster counters.
  assign in_col_inc   = WW'(in_col_q) + WW'(1);
  assign in_col_wrap  = in_col_inc >= weff;
  assign in_row_inc   = {1'b0, in_row_q} + (ROW_W+1)'(1);
  assign in_row_wrap  = in_row_inc >= {1'b0, heff};
  assign out_col_inc  = WW'(out_col_q) + WW'(1);
  assign out_col_wrap = out_col_inc >= weff;
  assign out_row_inc  = {1'b0, out_row_q} + (ROW_W+1)'(1);
  assign out_row_wrap = out_row_inc >= {1'b0, heff};

  // A pixel completes a window once one row and one pixel have arrived.
  assign emit_now = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));

  // A drain fetches the column after the current output position.
  assign drain_addr = out_col_wrap ? '0 : out_col_inc[CW-1:0];

  always_comb begin
    if (state_q == ST_XREAD) begin
      rd_addr = '0;
    end else if (s_axis_tuser == REQ_DRAIN) begin
      rd_addr = drain_addr;
    end else begin
      rd_addr = in_col_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Line store and window control.
  always_comb begin
    win_cmd.rd_en    = (accept && ((s_axis_tuser == REQ_PIXEL) || drain_pend_q))
                       || (state_q == ST_XREAD);
    win_cmd.shift_en = (state_q == ST_SHIFT) || (state_q == ST_XSHIFT);
    win_cmd.wr_en    = (state_q == ST_SHIFT) && is_pix_q;
    win_cmd.bot_pix  = ((state_q == ST_SHIFT) && is_pix_q) ? pix_q : '0;
  end

  sem_window #(
    .MAX_LINE (MAX_LINE),
    .CW       (CW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (win_cmd),
    .rd_addr_i (rd_addr),
    .taps_o    (win_taps)
  );

  // Zero the taps that fall outside the frame at the output position.
  assign row_first = (out_row_q == '0);
  assign row_last  = (out_row_q == heff - ROW_W'(1));
  assign col_first = (out_col_q == '0);
  assign col_last  = (WW'(out_col_q) == weff - WW'(1));

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        keep[r*3+c] = !((r == 0 && row_first) || (r == 2 && row_last) ||
                        (c == 0 && col_first) || (c == 2 && col_last));
      end
    end
    for (int l = 0; l < NUM_LANES; l++) begin
      for (int i = 0; i < TAPS; i++) begin
        lane_taps[l][i] = keep[i] ? win_taps[i][RGB_W-1-PIX_W*l -: PIX_W] : '0;
      end
    end
  end

  // One lane per color channel, red first.
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    sem_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (state_q == ST_EMIT),
      .taps_i  (lane_taps[l]),
      .res_o   (lane_res[l])
    );
  end

  assign lanes_done = lane_res[0].done && lane_res[1].done && lane_res[2].done;
  assign out_free   = !out_valid_q || m_axis_tready;

  // Request sequencer, raster counters and the merging output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_col_q     <= '0;
      in_row_q     <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      drain_pend_q <= 1'b0;
      is_pix_q     <= 1'b0;
      emit_q       <= 1'b0;
      extra_q      <= 1'b0;
      pix_q        <= '0;
      fend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is_pix_q <= (s_axis_tuser == REQ_PIXEL);
            pix_q    <= {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
            extra_q  <= 1'b0;
            if (s_axis_tuser == REQ_PIXEL) begin
              emit_q  <= emit_now;
              state_q <= ST_SHIFT;
              // A new pixel drops the outputs still pending from the last frame.
              if (drain_pend_q) begin
                drain_pend_q <= 1'b0;
                out_col_q    <= '0;
                out_row_q    <= '0;
              end
            end else if (drain_pend_q) begin
              emit_q  <= 1'b1;
              state_q <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          if (is_pix_q) begin
            if (in_col_wrap) begin
              in_col_q <= '0;
              if (in_row_wrap) begin
                in_row_q     <= '0;
                drain_pend_q <= 1'b1;
                extra_q      <= (heff == ROW_W'(1));
              end else begin
                in_row_q <= in_row_inc[ROW_W-1:0];
              end
            end else begin
              in_col_q <= in_col_inc[CW-1:0];
            end
            if (emit_q) begin
              state_q <= ST_EMIT;
            end else if (in_col_wrap && in_row_wrap && (heff == ROW_W'(1))) begin
              state_q <= ST_XREAD;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          fend_q <= row_last && col_last;
          if (out_col_wrap) begin
            out_col_q <= '0;
            out_row_q <= out_row_wrap ? '0 : out_row_inc[ROW_W-1:0];
            // The drain ends once the output position is back at the frame start.
            if (!is_pix_q && out_row_wrap) begin
              drain_pend_q <= 1'b0;
            end
          end else begin
            out_col_q <= out_col_inc[CW-1:0];
          end
          state_q <= extra_q ? ST_XREAD : ST_WAIT;
        end
        ST_XREAD: begin
          state_q <= ST_XSHIFT;
        end
        ST_XSHIFT: begin
          state_q <= emit_q ? ST_WAIT : ST_IDLE;
        end
        ST_WAIT: begin
          if (lanes_done && out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {lane_res[2].mag, lane_res[1].mag, lane_res[0].mag};
            out_last_q  <= fend_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // A register write restarts the frame.
      if (cfg_wr) begin
        in_col_q     <= '0;
        in_row_q     <= '0;
        out_col_q    <= '0;
        out_row_q    <= '0;
        drain_pend_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/sem_checker.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Port-level assertions on sequencing and the result handshake.
// ----------------------------------------------------------------------------
module sem_checker import sem_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [RGB_W-1:0] m_axis_tdata,
  input logic             m_axis_tlast
);

  // A stalled result keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Every pixel request keeps the block busy for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_PIXEL) |=> !s_axis_tready)
    else $error("pixel request did not occupy the sequencer");

  // A new result is only loaded while the sequencer is busy with its request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a request in progress");

  // No result is shown right after reset.
  assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[dv/tb_sobel_edge_magnitude_rgb.sv]
// ----------------------------------------------------------------------------
// Testbench for the RGB Sobel edge magnitude block
// Streams RGB pixel and drain requests through the block under random source
// gaps and sink stalls, predicts every edge result with an in-bench model of
// the line stores, the 3x3 window and the rounded root, and compares each
// result field by field. Frame geometry is changed over the APB port between
// phases and read back.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_rgb;
  timeunit 1ns;
  timeprecision 1ps;
  import sem_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int LINE_DEPTH    = 1024;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int REPORT_LIMIT  = 10;

  // One RGB word, lane 0 is red and sits in the lowest byte.
  typedef logic [NUM_LANES-1:0][PIX_W-1:0] rgb_t;

  typedef struct {
    rgb_t mag;
    logic frame_end;
  } edge_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [RGB_W-1:0]      s_axis_tdata;   // pixel_red, pixel_green, pixel_blue
  logic                  s_axis_tuser;   // req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [RGB_W-1:0]      m_axis_tdata;   // edge_red, edge_green, edge_blue
  logic                  m_axis_tlast;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned productive_items = 0;
  int unsigned settings_applied = 0;
  bit          gaps_on = 1'b1;

  sobel_edge_magnitude_rgb #(.MAX_LINE(LINE_DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predicts the edge results of accepted requests and checks what comes out.
  class edge_scoreboard;
    logic [FW_W-1:0]  width_reg;
    logic [ROW_W-1:0] height_reg;
    rgb_t             upper_line [LINE_DEPTH];
    rgb_t             middle_line [LINE_DEPTH];
    rgb_t             window [TAPS];
    int unsigned      in_col, in_row, out_col, out_row;
    bit               drain_pend;
    edge_result_t     expected_edges [$];
    int unsigned      mismatches;
    int unsigned      results_checked;

    function new();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      mismatches = 0;
      results_checked = 0;
      restart();
    endfunction

    // A register write starts a new frame and drops pending outputs.
    function void restart();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      drain_pend = 1'b0;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > LINE_DEPTH) w = LINE_DEPTH;
      return w;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_register(logic idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_FRAME_WIDTH) width_reg = value[FW_W-1:0];
      else height_reg = value[ROW_W-1:0];
      restart();
    endfunction

    function logic [APB_DATA_W-1:0] register_value(logic idx);
      if (idx == REG_FRAME_WIDTH) return APB_DATA_W'(width_reg);
      return APB_DATA_W'(height_reg);
    endfunction

    function void shift_in(rgb_t top, rgb_t mid, rgb_t bot);
      rgb_t col [3];
      col[0] = top;
      col[1] = mid;
      col[2] = bot;
      for (int r = 0; r < 3; r++) begin
        window[r*3]   = window[r*3+1];
        window[r*3+1] = window[r*3+2];
        window[r*3+2] = col[r];
      end
    endfunction

    // Rounded square root, clamped: count of k in 1..255 with s >= k*k-k+1.
    function int unsigned rounded_root(int unsigned s);
      int unsigned n;
      n = 0;
      for (int unsigned k = 1; k <= 255; k++) begin
        if (s >= k*k - k + 1) n++;
      end
      return n;
    endfunction

    // Gradient magnitude at the current output position, which then advances.
    function edge_result_t edge_at_output();
      rgb_t         t [TAPS];
      int           v [TAPS];
      int           gx, gy;
      int unsigned  w, h;
      edge_result_t res;
      w = eff_width();
      h = eff_height();
      t = window;
      if (out_row == 0) begin
        t[0] = '0; t[1] = '0; t[2] = '0;
      end
      if (out_row == h - 1) begin
        t[6] = '0; t[7] = '0; t[8] = '0;
      end
      if (out_col == 0) begin
        t[0] = '0; t[3] = '0; t[6] = '0;
      end
      if (out_col == w - 1) begin
        t[2] = '0; t[5] = '0; t[8] = '0;
      end
      for (int ch = 0; ch < NUM_LANES; ch++) begin
        for (int i = 0; i < TAPS; i++) v[i] = int'(t[i][ch]);
        gx = (v[2] + 2*v[5] + v[8]) - (v[0] + 2*v[3] + v[6]);
        gy = (v[6] + 2*v[7] + v[8]) - (v[0] + 2*v[1] + v[2]);
        res.mag[ch] = PIX_W'(rounded_root(gx*gx + gy*gy));
      end
      res.frame_end = (out_row == h - 1) && (out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) out_row = 0;
      end
      return res;
    endfunction

    // Notes one accepted request; returns 0 when the block ignores it.
    function bit note_request(logic kind, rgb_t pix);
      int unsigned w, h, c, k;
      rgb_t        top, mid;
      bit          ready, frame_done;
      w = eff_width();
      h = eff_height();
      frame_done = 1'b0;
      if (kind == REQ_DRAIN) begin
        if (!drain_pend) return 1'b0;
        k = out_col + 1;
        if (k >= w) k = 0;
        shift_in(upper_line[k], middle_line[k], '0);
        expected_edges.push_back(edge_at_output());
        if (out_row == 0 && out_col == 0) drain_pend = 1'b0;
        return 1'b1;
      end
      // A pixel during the drain of a finished frame drops what is pending.
      if (drain_pend) begin
        drain_pend = 1'b0;
        out_row = 0;
        out_col = 0;
      end
      c = (in_col < LINE_DEPTH) ? in_col : 0;
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c] = mid;
      middle_line[c] = pix;
      shift_in(top, mid, pix);
      ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
      if (ready) expected_edges.push_back(edge_at_output());
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_done = 1'b1;
        end
      end
      if (frame_done) begin
        drain_pend = 1'b1;
        // A one-row frame pushes one extra empty column into the window.
        if (h == 1) shift_in(upper_line[0], middle_line[0], '0);
      end
      return 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
    endfunction

    function void check_edge_result(rgb_t mag, logic frame_end);
      edge_result_t want;
      results_checked++;
      if (expected_edges.size() == 0) begin
        flag($sformatf("unexpected edge result r=%0d g=%0d b=%0d last=%0b",
                       mag[0], mag[1], mag[2], frame_end));
        return;
      end
      want = expected_edges.pop_front();
      if (mag !== want.mag || frame_end !== want.frame_end) begin
        flag($sformatf({"edge result %0d: expected r=%0d g=%0d b=%0d last=%0b,",
                        " got r=%0d g=%0d b=%0d last=%0b"}, results_checked,
                       want.mag[0], want.mag[1], want.mag[2], want.frame_end,
                       mag[0], mag[1], mag[2], frame_end));
      end
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction
  endclass

  edge_scoreboard sb;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog against a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still outstanding.",
             cycle_count, sb.pending());
    $display("*** FAILED ***");
    $finish;
  end

  // Check every result request accepted on the master side.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
      sb.check_edge_result(rgb_t'(m_axis_tdata), m_axis_tlast);
  end

  // Sink stalls: mostly ready, short and occasional long stalls, some clear runs.
  initial begin
    int unsigned hold;
    bit          level;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin level = 1'b1; hold = $urandom_range(1, 20);  end
        5, 6, 7:       begin level = 1'b0; hold = $urandom_range(1, 3);   end
        8:             begin level = 1'b0; hold = $urandom_range(10, 40); end
        default:       begin level = 1'b1; hold = $urandom_range(50, 200); end
      endcase
      m_axis_tready <= level;
      repeat (hold) @(posedge clk_i);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic rgb_t rand_pixel();
    rgb_t p;
    p = rgb_t'($urandom);
    case ($urandom_range(0, 3))
      0: for (int ch = 0; ch < NUM_LANES; ch++) p[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      1: for (int ch = 0; ch < NUM_LANES; ch++) p[ch] = PIX_W'($urandom_range(0, 15));
      default: ;
    endcase
    return p;
  endfunction

  // Present one request on the slave side and hold it until accepted.
  task automatic send_item(logic kind, rgb_t pix);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (sb.note_request(kind, pix)) productive_items++;
    items_sent++;
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_item(REQ_PIXEL, rand_pixel());
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_item(REQ_DRAIN, rgb_t'($urandom));
  endtask

  // Let every expected result out, then let an in-flight request finish.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: a setup phase, an access phase, then an idle phase.
  task automatic apb_access(logic idx, bit is_write, logic [APB_DATA_W-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= APB_ADDR_W'(idx) << 2;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (is_write) sb.write_register(idx, wdata);
    else if (prdata !== sb.register_value(idx))
      sb.flag($sformatf("register %0d read back %0h, expected %0h",
                        idx, prdata, sb.register_value(idx)));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(int unsigned width, int unsigned height);
    wait_idle();
    apb_access(REG_FRAME_WIDTH, 1'b1, APB_DATA_W'(width));
    apb_access(REG_FRAME_WIDTH, 1'b0, '0);
    apb_access(REG_FRAME_HEIGHT, 1'b1, APB_DATA_W'(height));
    apb_access(REG_FRAME_HEIGHT, 1'b0, '0);
    settings_applied++;
  endtask

  // Main sequence.
  initial begin
    int unsigned w_val, h_val, w_eff, h_eff, pend, frames, style, start;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PIXEL;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset geometry: a drain with nothing pending, then two extreme pixels.
    send_item(REQ_DRAIN, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, rgb_t'(24'h000000));
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));

    // 3x3 frame with saturated channels; an early drain is ignored.
    configure(3, 3);
    send_item(REQ_PIXEL, '{8'h00, 8'h00, 8'hFF});
    send_item(REQ_PIXEL, '{8'h00, 8'hFF, 8'h00});
    send_item(REQ_PIXEL, '{8'hFF, 8'h00, 8'h00});
    send_item(REQ_DRAIN, rgb_t'(24'hA5A5A5));
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, rgb_t'(24'h000000));
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, '{8'hFF, 8'h55, 8'hAA});
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, '{8'hFE, 8'h80, 8'h01});
    send_drains(5);

    // Single-row frame, cut short by the next frame, then drained fully.
    configure(4, 1);
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, rgb_t'(24'h000000));
    send_item(REQ_PIXEL, rgb_t'(24'hFFFFFF));
    send_item(REQ_PIXEL, rgb_t'(24'h000000));
    send_drains(2);
    send_pixels(4);
    send_drains(5);

    // Widest rows: enough pixels past one full line to get results.
    gaps_on = 1'b0;
    configure(1024, 4095);
    send_pixels(1030);
    gaps_on = 1'b1;
    configure(2047, 0);
    send_pixels(6);
    send_drains(1);
    configure(0, 2);
    send_pixels(2);
    send_drains(3);

    // Random phases of mostly well-formed frames with some broken sequences.
    start = productive_items;
    while (productive_items - start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w_val = 1;
        1:       w_val = 0;
        8:       w_val = $urandom_range(13, 40);
        default: w_val = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h_val = 1;
        1:       h_val = 0;
        9:       h_val = $urandom_range(7, 12);
        default: h_val = $urandom_range(2, 6);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      configure(w_val, h_val);
      w_eff = sb.eff_width();
      h_eff = sb.eff_height();
      pend = (h_eff == 1) ? w_eff : w_eff + 1;
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        style = $urandom_range(0, 9);
        if (style <= 7) begin
          send_pixels(w_eff * h_eff);
          if (style <= 6) send_drains(pend + $urandom_range(0, 2));
          else send_drains($urandom_range(0, pend - 1));
        end else if (style == 8) begin
          repeat ($urandom_range(1, 8))
            send_item($urandom_range(0, 1) ? REQ_DRAIN : REQ_PIXEL, rand_pixel());
        end else begin
          send_pixels($urandom_range(1, w_eff * h_eff));
          send_drains($urandom_range(0, 2));
        end
      end
    end

    wait_idle();
    $display("Sent %0d requests (%0d not ignored) over %0d frame geometries.",
             items_sent, productive_items, settings_applied);
    $display("Checked %0d edge results in %0d cycles.", sb.results_checked, cycle_count);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sem_pkg.sv
rtl/sem_window.sv
rtl/sem_lane.sv
rtl/sobel_edge_magnitude_rgb.sv
rtl/sem_checker.sv
dv/tb_sobel_edge_magnitude_rgb.sv
